[rtl/chd_pkg.sv]
// Package for the chunked body decoder: phase and status codes, result struct,
// and the hex digit decode helper. No dependencies.
package chd_pkg;

    localparam int unsigned LEN_BITS_DEF = 32;

    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [3:0] HEX_TEN = 4'd10;

    typedef enum logic [2:0] {
        PH_SIZE = 3'd0,
        PH_EXT  = 3'd1,
        PH_LF   = 3'd2,
        PH_DATA = 3'd3,
        PH_DCR  = 3'd4,
        PH_DLF  = 3'd5,
        PH_HALT = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_RUN    = 3'd0,
        ST_DONE   = 3'd1,
        ST_BADDIG = 3'd2,
        ST_NODIG  = 3'd3,
        ST_NOLF   = 3'd4,
        ST_NOCRLF = 3'd5,
        ST_TRUNC  = 3'd6,
        ST_OVF    = 3'd7
    } t_status;

    typedef struct packed {
        logic       emit;
        logic       data_valid;
        logic [7:0] data_byte;
        t_status    status;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.val = c[3:0] - 4'd1 + HEX_TEN;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

[rtl/http_chunked_body_decoder_core.sv]
// Top level of the HTTP chunked body decoder: state registers, step logic and
// result register. Depends on chd_pkg, chd_step, chd_out_reg.
//
// Usage: raw body bytes enter on the slave stream, one byte per transfer, with
// tlast on the final byte of each body. Decoded payload bytes and status
// reports leave on the master stream. Framing bytes (size digits, extensions,
// CR LF) produce no output transfer; payload bytes, done, errors and
// truncation produce exactly one.
// Output timing: the input transfer loads the result register, so output valid
// rises in the cycle after it. Throughput: one byte per cycle while the result
// register is free; combinational step logic feeds the phase, count and digit registers.
// Stall: one result register sits on the output; input is taken whenever that
// register is empty or being drained in the same cycle, so a stalled receiver
// holds the input side only while a result is waiting.
// After done or an error, bytes are dropped until tlast; tlast always returns
// the decoder to the start of a size line.
// Reset: synchronous, active low; clears the phase to size line start, the
// count and digit flag to zero, and empties the result register.
module http_chunked_body_decoder_core #(
    parameter int unsigned LEN_BITS = chd_pkg::LEN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] byte_in
    input  logic        i_s_axis_tlast,  // frame_last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [7:0] data_byte, [10:8] status, [15:11] zero
    output logic [0:0]  o_m_axis_tuser   // [0] data_valid
);
    import chd_pkg::*;

    t_phase              r_phase, n_phase;
    logic [LEN_BITS-1:0] r_len, n_len;
    logic                r_digit, n_digit;
    t_result             step_res, out_res;
    logic                in_acc;
    logic                out_free;

    assign o_s_axis_tready = out_free;
    assign in_acc          = i_s_axis_tvalid && out_free;

    chd_step #(
        .LEN_BITS(LEN_BITS)
    ) u_step (
        .i_phase     (r_phase),
        .i_len       (r_len),
        .i_digit_seen(r_digit),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_phase     (n_phase),
        .o_len       (n_len),
        .o_digit_seen(n_digit),
        .o_res       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_len   <= '0;
            r_digit <= 1'b0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_digit <= n_digit;
        end
    end

    chd_out_reg u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (in_acc && step_res.emit),
        .i_res  (step_res),
        .i_ready(i_m_axis_tready),
        .o_valid(o_m_axis_tvalid),
        .o_free (out_free),
        .o_res  (out_res)
    );

    assign o_m_axis_tdata = {5'd0, out_res.status, out_res.data_byte};
    assign o_m_axis_tuser = out_res.data_valid;

    a_data_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            out_res.status == ST_RUN || out_res.status == ST_TRUNC)
        else $error("payload transfer with non-running status");

    a_byte_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[7:0] == 8'h00)
        else $error("status transfer with nonzero data byte");

    a_last_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_s_axis_tlast |=> r_phase == PH_SIZE && r_len == '0 && !r_digit)
        else $error("decoder not restarted after last byte");

    a_data_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_len != '0)
        else $error("data phase with zero bytes left");

endmodule

[rtl/chd_step.sv]
// Per-byte step logic of the chunked body decoder: next phase, size/count and
// the result for one transfer. Depends on chd_pkg.
module chd_step #(
    parameter int unsigned LEN_BITS = chd_pkg::LEN_BITS_DEF
) (
    input  chd_pkg::t_phase      i_phase,
    input  logic [LEN_BITS-1:0]  i_len,
    input  logic                 i_digit_seen,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output chd_pkg::t_phase      o_phase,
    output logic [LEN_BITS-1:0]  o_len,
    output logic                 o_digit_seen,
    output chd_pkg::t_result     o_res
);
    import chd_pkg::*;

    t_hex                hx;
    t_phase              n_phase;
    logic [LEN_BITS-1:0] n_len;
    logic                n_digit;
    logic [LEN_BITS-1:0] len_dec;
    logic                ovf;

    assign hx      = hex_decode(i_byte);
    assign len_dec = i_len - LEN_BITS'(1);
    assign ovf     = |i_len[LEN_BITS-1 -: 4];

    always_comb begin
        n_phase = i_phase;
        n_len   = i_len;
        n_digit = i_digit_seen;
        case (i_phase)
            PH_SIZE: begin
                if (i_byte == CH_SEMI || i_byte == CH_CR) begin
                    if (!i_digit_seen) n_phase = PH_HALT;
                    else n_phase = (i_byte == CH_SEMI) ? PH_EXT : PH_LF;
                end else if (!hx.ok || ovf) begin
                    n_phase = PH_HALT;
                end else begin
                    n_len   = {i_len[LEN_BITS-5:0], hx.val};
                    n_digit = 1'b1;
                end
            end
            PH_EXT:  if (i_byte == CH_CR) n_phase = PH_LF;
            PH_LF: begin
                if (i_byte != CH_LF || i_len == '0) n_phase = PH_HALT;
                else n_phase = PH_DATA;
            end
            PH_DATA: begin
                n_len = len_dec;
                if (len_dec == '0) n_phase = PH_DCR;
            end
            PH_DCR:  n_phase = (i_byte == CH_CR) ? PH_DLF : PH_HALT;
            PH_DLF: begin
                if (i_byte == CH_LF) begin
                    n_phase = PH_SIZE;
                    n_len   = '0;
                    n_digit = 1'b0;
                end else begin
                    n_phase = PH_HALT;
                end
            end
            default: n_phase = i_phase;
        endcase
        if (i_last) begin
            n_phase = PH_SIZE;
            n_len   = '0;
            n_digit = 1'b0;
        end
    end

    assign o_phase      = n_phase;
    assign o_len        = n_len;
    assign o_digit_seen = n_digit;

    always_comb begin
        o_res = '{emit: 1'b0, data_valid: 1'b0, data_byte: 8'h00, status: ST_RUN};
        case (i_phase)
            PH_SIZE: begin
                if (i_byte == CH_SEMI || i_byte == CH_CR) begin
                    if (!i_digit_seen) begin
                        o_res.emit   = 1'b1;
                        o_res.status = ST_NODIG;
                    end
                end else if (!hx.ok) begin
                    o_res.emit   = 1'b1;
                    o_res.status = ST_BADDIG;
                end else if (ovf) begin
                    o_res.emit   = 1'b1;
                    o_res.status = ST_OVF;
                end
            end
            PH_LF: begin
                if (i_byte != CH_LF) begin
                    o_res.emit   = 1'b1;
                    o_res.status = ST_NOLF;
                end else if (i_len == '0) begin
                    o_res.emit   = 1'b1;
                    o_res.status = ST_DONE;
                end
            end
            PH_DATA: begin
                o_res.emit       = 1'b1;
                o_res.data_valid = 1'b1;
                o_res.data_byte  = i_byte;
            end
            PH_DCR: begin
                if (i_byte != CH_CR) begin
                    o_res.emit   = 1'b1;
                    o_res.status = ST_NOCRLF;
                end
            end
            PH_DLF: begin
                if (i_byte != CH_LF) begin
                    o_res.emit   = 1'b1;
                    o_res.status = ST_NOCRLF;
                end
            end
            default: o_res.emit = 1'b0;
        endcase
        // truncated: last byte while the body is still open
        if (i_last && !o_res.emit && i_phase != PH_HALT && i_phase != PH_EXT) begin
            o_res.emit   = 1'b1;
            o_res.status = ST_TRUNC;
        end else if (i_last && i_phase == PH_EXT) begin
            o_res.emit   = 1'b1;
            o_res.status = ST_TRUNC;
        end else if (i_last && i_phase == PH_DATA) begin
            o_res.status = ST_TRUNC;
        end
    end

endmodule

[rtl/chd_out_reg.sv]
// Result register of the chunked body decoder: holds one result transfer until
// the downstream side takes it. Depends on chd_pkg.
module chd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  chd_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_free,
    output chd_pkg::t_result o_res
);
    import chd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
